// ===== src/aqt_pkg.sv =====
// shared types and constants of the availability quantile tracker
// no dependencies; imported by the controller, the datapath and the top level
package aqt_pkg;

    // event codes carried by a transaction
    typedef enum logic [1:0] {
        ACT_END   = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_CONFIDENCE = 2'd1,
        CFG_LIMIT      = 2'd2,
        CFG_BIRTH      = 2'd3
    } t_cfg_idx;

    localparam logic       ENABLE_RST     = 1'b1;
    localparam logic [8:0] CONF_DEFAULT   = 9'd205;
    localparam logic [8:0] CONF_MAX       = 9'd256;
    localparam logic [7:0] LIMIT_RST      = 8'd100;
    localparam logic [15:0] FRAC_SAT      = 16'hFFFF;
    localparam logic [31:0] EST_SAT       = 32'hFFFF_FFFF;

    // micro-operations issued by the controller to the datapath
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_END_SETUP,
        OP_IDX_RD,
        OP_IDX_INC,
        OP_SHF_SETUP,
        OP_SHF_RD,
        OP_SHF_WR,
        OP_INS_WR,
        OP_START_SETUP,
        OP_HLV_RD,
        OP_HLV_WR,
        OP_HLV_END,
        OP_RC_SETUP,
        OP_EST_MUL,
        OP_EST_SAT,
        OP_EST_K,
        OP_EST_RD,
        OP_EST_PICK,
        OP_DIV_SETUP,
        OP_DIV_STEP,
        OP_DIV_END
    } t_op;

    // status flags returned by the datapath
    typedef struct packed {
        logic    enable;
        t_action action;
        logic    open;
        logic    ge_limit;
        logic    idx_lt_count;
        logic    rd_le_len;
        logic    rd_lt_len;
        logic    idx_lt_depth;
        logic    j_gt_idx;
        logic    idx_lt_keep;
        logic    num_ge_den;
        logic    div_last;
    } t_status;

endpackage

// ===== src/aqt_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module aqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/aqt_ctrl.sv =====
// controller state machine of the availability quantile tracker
// depends on aqt_pkg; drives micro-operations into aqt_dp
module aqt_ctrl
    import aqt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_op     o_op,
    output logic    o_busy,
    output logic    o_valid
);

    typedef enum logic [20:0] {
        S_IDLE     = 21'h000001,
        S_DECIDE   = 21'h000002,
        S_INS_CHK  = 21'h000004,
        S_INS_CMP  = 21'h000008,
        S_INS_POS  = 21'h000010,
        S_SHF_CHK  = 21'h000020,
        S_SHF_WR   = 21'h000040,
        S_HLV_CHK  = 21'h000080,
        S_HLV_WR   = 21'h000100,
        S_RC       = 21'h000200,
        S_SCN_CHK  = 21'h000400,
        S_SCN_CMP  = 21'h000800,
        S_EST_MUL  = 21'h001000,
        S_EST_SAT  = 21'h002000,
        S_EST_K    = 21'h004000,
        S_EST_RD   = 21'h008000,
        S_EST_PICK = 21'h010000,
        S_DIV_SET  = 21'h020000,
        S_DIV      = 21'h040000,
        S_DIV_END  = 21'h080000,
        S_DONE     = 21'h100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and operation
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LATCH;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (!i_status.enable) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_status.action)
                        ACT_END: begin
                            if (i_status.open) begin
                                o_op    = OP_END_SETUP;
                                n_state = S_INS_CHK;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        ACT_START: begin
                            if (!i_status.open) begin
                                o_op    = OP_START_SETUP;
                                n_state = i_status.ge_limit ? S_HLV_CHK : S_RC;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        ACT_TICK: n_state = S_RC;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            // find the insert position
            S_INS_CHK: begin
                if (i_status.idx_lt_count) begin
                    o_op    = OP_IDX_RD;
                    n_state = S_INS_CMP;
                end else begin
                    n_state = S_INS_POS;
                end
            end
            S_INS_CMP: begin
                if (i_status.rd_le_len) begin
                    o_op    = OP_IDX_INC;
                    n_state = S_INS_CHK;
                end else begin
                    n_state = S_INS_POS;
                end
            end
            S_INS_POS: begin
                if (i_status.idx_lt_depth) begin
                    o_op    = OP_SHF_SETUP;
                    n_state = S_SHF_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            // move larger entries up by one, then write the new one
            S_SHF_CHK: begin
                if (i_status.j_gt_idx) begin
                    o_op    = OP_SHF_RD;
                    n_state = S_SHF_WR;
                end else begin
                    o_op    = OP_INS_WR;
                    n_state = S_DONE;
                end
            end
            S_SHF_WR: begin
                o_op    = OP_SHF_WR;
                n_state = S_SHF_CHK;
            end
            // keep the odd positions
            S_HLV_CHK: begin
                if (i_status.idx_lt_keep) begin
                    o_op    = OP_HLV_RD;
                    n_state = S_HLV_WR;
                end else begin
                    o_op    = OP_HLV_END;
                    n_state = S_RC;
                end
            end
            S_HLV_WR: begin
                o_op    = OP_HLV_WR;
                n_state = S_HLV_CHK;
            end
            S_RC: begin
                o_op    = OP_RC_SETUP;
                n_state = i_status.open ? S_SCN_CHK : S_DIV_SET;
            end
            // skip entries shorter than the idle time
            S_SCN_CHK: begin
                if (i_status.idx_lt_count) begin
                    o_op    = OP_IDX_RD;
                    n_state = S_SCN_CMP;
                end else begin
                    n_state = S_EST_MUL;
                end
            end
            S_SCN_CMP: begin
                if (i_status.rd_lt_len) begin
                    o_op    = OP_IDX_INC;
                    n_state = S_SCN_CHK;
                end else begin
                    n_state = S_EST_K;
                end
            end
            S_EST_MUL: begin
                o_op    = OP_EST_MUL;
                n_state = S_EST_SAT;
            end
            S_EST_SAT: begin
                o_op    = OP_EST_SAT;
                n_state = S_DIV_SET;
            end
            S_EST_K: begin
                o_op    = OP_EST_K;
                n_state = S_EST_RD;
            end
            S_EST_RD: begin
                o_op    = OP_EST_RD;
                n_state = S_EST_PICK;
            end
            S_EST_PICK: begin
                o_op    = OP_EST_PICK;
                n_state = S_DIV_SET;
            end
            // fraction by restoring division
            S_DIV_SET: begin
                o_op    = OP_DIV_SETUP;
                n_state = i_status.num_ge_den ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_op    = OP_DIV_STEP;
                n_state = i_status.div_last ? S_DIV_END : S_DIV;
            end
            S_DIV_END: begin
                o_op    = OP_DIV_END;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// ===== src/aqt_dp.sv =====
// datapath of the availability quantile tracker: registers, history ram,
// estimate multiplier and serial divider; depends on aqt_pkg and aqt_ram
module aqt_dp
    import aqt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_now,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_status     o_status,
    output logic [31:0] o_estimate,
    output logic [15:0] o_avail_fraction,
    output logic [31:0] o_last_interval,
    output logic        o_available,
    output logic [31:0] o_open_since,
    output logic [7:0]  o_history_count
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(HISTORY_DEPTH - 1);

    // configuration
    logic        r_enable;
    logic [8:0]  r_conf;
    logic [7:0]  r_limit;
    logic [31:0] r_birth;

    // tracker state
    t_action     r_action;
    logic [31:0] r_now;
    logic [CW-1:0] r_count;
    logic        r_open;
    logic [31:0] r_start;
    logic [31:0] r_total;
    logic [31:0] r_recent;
    logic [31:0] r_est;
    logic [15:0] r_frac;

    // work registers
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_pick;
    logic [31:0]   r_len;
    logic [41:0]   r_prod;
    logic [32:0]   r_num;
    logic [31:0]   r_den;
    logic [31:0]   r_rem;
    logic [15:0]   r_q;
    logic [3:0]    r_cnt;

    // ram port
    logic          w_we;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic [31:0]   w_rd_data;

    logic [31:0]   w_idle;
    logic [8:0]    w_conf;
    logic [9:0]    w_conf_hi;
    logic [8:0]    w_conf_lo;
    logic [CW-1:0] w_keep;
    logic [CW:0]   w_hlv_src;
    logic [CW-1:0] w_jm1;
    logic [CW-1:0] w_n;
    logic [CW+8:0] w_kprod;
    logic [CW:0]   w_k;
    logic [CW-1:0] w_kc;
    logic [32:0]   w_rem2;
    logic          w_sub;

    assign w_idle    = r_now - r_start;
    assign w_conf    = (r_conf > CONF_MAX) ? CONF_DEFAULT : r_conf;
    assign w_conf_hi = 10'd512 - {1'b0, w_conf};
    assign w_conf_lo = CONF_MAX - w_conf;
    assign w_keep    = r_count >> 1;
    assign w_hlv_src = {r_idx, 1'b1};
    assign w_jm1     = r_j - 1'b1;

    // quantile index within the remaining entries, clamped to the last
    assign w_n     = r_count - r_idx;
    assign w_kprod = (CW+9)'(w_n) * (CW+9)'(w_conf_lo);
    assign w_k     = w_kprod[CW+8:8];
    assign w_kc    = (w_k >= {1'b0, w_n}) ? (w_n - 1'b1) : w_k[CW-1:0];

    // one restoring division step
    assign w_rem2 = {r_rem, 1'b0};
    assign w_sub  = (w_rem2 >= {1'b0, r_den});

    // ram address and write selection
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_idx[AW-1:0];
        w_wr_data = w_rd_data;
        w_rd_addr = r_idx[AW-1:0];
        unique case (i_op)
            OP_HLV_RD: w_rd_addr = w_hlv_src[AW-1:0];
            OP_SHF_RD: w_rd_addr = w_jm1[AW-1:0];
            OP_EST_RD: w_rd_addr = r_pick[AW-1:0];
            OP_SHF_WR: begin
                w_we      = 1'b1;
                w_wr_addr = r_j[AW-1:0];
            end
            OP_HLV_WR: w_we = 1'b1;
            OP_INS_WR: begin
                w_we      = 1'b1;
                w_wr_data = r_len;
            end
            default: ;
        endcase
    end

    aqt_ram #(
        .WIDTH (32),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= ENABLE_RST;
            r_conf   <= CONF_DEFAULT;
            r_limit  <= LIMIT_RST;
            r_birth  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:     r_enable <= i_cfg_data[0];
                CFG_CONFIDENCE: r_conf   <= i_cfg_data[8:0];
                CFG_LIMIT:      r_limit  <= i_cfg_data[7:0];
                CFG_BIRTH:      r_birth  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_open   <= 1'b0;
            r_start  <= '0;
            r_total  <= '0;
            r_recent <= '0;
            r_est    <= '0;
            r_frac   <= '0;
        end else begin
            unique case (i_op)
                OP_END_SETUP: begin
                    r_recent <= w_idle;
                    r_total  <= r_total + w_idle;
                    r_open   <= 1'b0;
                    r_start  <= '0;
                    r_est    <= '0;
                end
                OP_START_SETUP: begin
                    r_open  <= 1'b1;
                    r_start <= r_now;
                end
                OP_INS_WR: begin
                    if (r_count < DEPTH_C) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_HLV_END:  r_count <= w_keep;
                OP_EST_SAT:  r_est   <= (|r_prod[41:40]) ? EST_SAT : r_prod[39:8];
                OP_EST_PICK: r_est   <= w_rd_data;
                OP_DIV_SETUP: begin
                    if (r_num >= {1'b0, r_den}) begin
                        r_frac <= FRAC_SAT;
                    end
                end
                OP_DIV_END:  r_frac <= r_q;
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LATCH: begin
                r_action <= t_action'(i_action);
                r_now    <= i_now;
            end
            OP_END_SETUP: begin
                r_len <= w_idle;
                r_idx <= '0;
            end
            OP_START_SETUP: r_idx <= '0;
            OP_IDX_INC:     r_idx <= r_idx + 1'b1;
            OP_SHF_SETUP:   r_j   <= (r_count < DEPTH_C) ? r_count : LAST_C;
            OP_SHF_WR:      r_j   <= w_jm1;
            OP_HLV_WR:      r_idx <= r_idx + 1'b1;
            OP_RC_SETUP: begin
                r_len <= w_idle;
                r_num <= {1'b0, r_total} + (r_open ? {1'b0, w_idle} : 33'd0);
                r_den <= r_now - r_birth;
                r_idx <= '0;
            end
            OP_EST_MUL: r_prod <= 42'(r_len) * 42'(w_conf_hi);
            OP_EST_K:   r_pick <= r_idx + w_kc;
            OP_DIV_SETUP: begin
                r_rem <= r_num[31:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_sub ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
                r_q   <= {r_q[14:0], w_sub};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    // status toward the controller
    always_comb begin
        o_status.enable       = r_enable;
        o_status.action       = r_action;
        o_status.open         = r_open;
        o_status.ge_limit     = (32'(r_count) >= 32'(r_limit));
        o_status.idx_lt_count = (r_idx < r_count);
        o_status.rd_le_len    = (w_rd_data <= r_len);
        o_status.rd_lt_len    = (w_rd_data < r_len);
        o_status.idx_lt_depth = (r_idx < DEPTH_C);
        o_status.j_gt_idx     = (r_j > r_idx);
        o_status.idx_lt_keep  = (r_idx < w_keep);
        o_status.num_ge_den   = (r_num >= {1'b0, r_den});
        o_status.div_last     = (r_cnt == 4'd15);
    end

    assign o_estimate       = r_est;
    assign o_avail_fraction = r_frac;
    assign o_last_interval  = r_recent;
    assign o_available      = r_open;
    assign o_open_since     = r_start;
    assign o_history_count  = 8'(r_count);

endmodule

// ===== src/availability_quantile_tracker.sv =====
// an ignored transaction passes decide and strobes in done; an end adds steps per compared
// and per shifted entry; a start or tick adds steps per skipped entry, the estimate steps
// while open and a divider that stops at setup when saturated; a start may first halve
// (steps per kept entry); one transaction at a time, the next accepted in the cycle after
// the strobe at the earliest; the receiver cannot stall; reset: synchronous active low,
// clears state, defaults; depends on aqt_pkg, aqt_ctrl, aqt_dp, aqt_ram
module availability_quantile_tracker
    import aqt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_now,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_estimate,
    output logic [15:0] o_avail_fraction,
    output logic [31:0] o_last_interval,
    output logic        o_available,
    output logic [31:0] o_open_since,
    output logic [7:0]  o_history_count
);

    t_op     w_op;
    t_status w_status;

    // sequencing
    aqt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // storage and arithmetic
    aqt_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .i_action         (i_action),
        .i_now            (i_now),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_status         (w_status),
        .o_estimate       (o_estimate),
        .o_avail_fraction (o_avail_fraction),
        .o_last_interval  (o_last_interval),
        .o_available      (o_available),
        .o_open_since     (o_open_since),
        .o_history_count  (o_history_count)
    );

endmodule

// ===== src/aqt_checker.sv =====
// port level checks of the availability quantile tracker and their bind
// depends on availability_quantile_tracker
module aqt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_available,
    input logic [31:0] o_open_since
);

    // a result is only shown while a transaction is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe while idle");

    // after a result the block is free again
    a_valid_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid) else $error("busy after result");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept not seen");

    // closed period reports zero start time
    a_since_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_available |-> (o_open_since == 32'd0)) else $error("stale start time");

    // reset leaves the block idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid && !o_available) else $error("not idle after reset");

endmodule

bind availability_quantile_tracker aqt_checker u_aqt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_available  (o_available),
    .o_open_since (o_open_since)
);

// ===== bench/aqt_checker.sv =====
`timescale 1ns / 1ps
// transaction checker for the availability quantile tracker: tracks configuration writes,
// predicts each result from accepted transactions and compares it; depends on aqt_pkg
module aqt_tb_checker
    import aqt_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_now,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic [31:0] i_estimate,
    input  logic [15:0] i_avail_fraction,
    input  logic [31:0] i_last_interval,
    input  logic        i_available,
    input  logic [31:0] i_open_since,
    input  logic [7:0]  i_history_count,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [31:0] estimate;
        logic [15:0] fraction;
        logic [31:0] last_len;
        logic        open;
        logic [31:0] since;
        logic [7:0]  count;
    } t_status_word;

    // tracker state as predicted
    logic [31:0] lengths [DEPTH];
    int          n_stored;
    logic        period_up;
    logic [31:0] opened_at;
    logic [31:0] total_up;
    logic [31:0] last_len;
    logic [31:0] est_now;
    logic [15:0] frac_now;

    // register copies
    logic        en_reg;
    logic [8:0]  conf_reg;
    logic [7:0]  limit_reg;
    logic [31:0] birth_reg;

    t_status_word status_q[$];

    // sorted insertion; the largest value falls off a full history
    task automatic insert_length(input logic [31:0] len);
        int pos;
        int j;
        pos = 0;
        while (pos < n_stored && lengths[pos] <= len) pos++;
        if (pos < DEPTH) begin
            j = (n_stored < DEPTH) ? n_stored : DEPTH - 1;
            while (j > pos) begin
                lengths[j] = lengths[j-1];
                j--;
            end
            lengths[pos] = len;
            if (n_stored < DEPTH) n_stored++;
        end
    endtask

    // keep the odd positions only
    task automatic halve_lengths();
        int keep;
        keep = n_stored / 2;
        for (int j = 0; j < keep; j++) lengths[j] = lengths[2*j+1];
        n_stored = keep;
    endtask

    // estimate and available fraction at time t
    task automatic refresh_outputs(input logic [31:0] t);
        logic [8:0]  conf;
        logic [63:0] num;
        logic [31:0] den;
        logic [31:0] idle;
        logic [63:0] prod;
        logic [63:0] q;
        int i;
        int n;
        int k;
        conf = (conf_reg > CONF_MAX) ? CONF_DEFAULT : conf_reg;
        num  = {32'd0, total_up};
        den  = t - birth_reg;
        if (period_up) begin
            idle = t - opened_at;
            i = 0;
            while (i < n_stored && lengths[i] < idle) i++;
            if (i == n_stored) begin
                prod = (64'(idle) * 64'(10'd512 - conf)) >> 8;
                est_now = (prod > 64'(EST_SAT)) ? EST_SAT : prod[31:0];
            end else begin
                n = n_stored - i;
                k = int'((64'(n) * 64'(9'd256 - conf)) >> 8);
                if (k >= n) k = n - 1;
                est_now = lengths[i+k];
            end
            num += 64'(idle);
        end
        if (den == 0) begin
            frac_now = FRAC_SAT;
        end else begin
            q = (num << 16) / 64'(den);
            frac_now = (q > 64'(FRAC_SAT)) ? FRAC_SAT : q[15:0];
        end
    endtask

    task automatic apply_event(input t_action act, input logic [31:0] t);
        if (en_reg) begin
            case (act)
                ACT_END: begin
                    if (period_up) begin
                        last_len = t - opened_at;
                        insert_length(last_len);
                        total_up += last_len;
                        period_up = 1'b0;
                        opened_at = '0;
                        est_now   = '0;
                    end
                end
                ACT_START: begin
                    if (!period_up) begin
                        period_up = 1'b1;
                        opened_at = t;
                        if (n_stored >= limit_reg) halve_lengths();
                        refresh_outputs(t);
                    end
                end
                ACT_TICK: refresh_outputs(t);
                default: ;
            endcase
        end
        status_q.push_back('{est_now, frac_now, last_len, period_up,
                             period_up ? opened_at : 32'd0, 8'(n_stored)});
    endtask

    // watch configuration, accepted transactions and result strobes
    always @(posedge i_clk) begin
        t_status_word want;
        if (!i_rst_n) begin
            n_stored  = 0;
            period_up = 1'b0;
            opened_at = '0;
            total_up  = '0;
            last_len  = '0;
            est_now   = '0;
            frac_now  = '0;
            en_reg    = ENABLE_RST;
            conf_reg  = CONF_DEFAULT;
            limit_reg = LIMIT_RST;
            birth_reg = '0;
            status_q.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENABLE:     en_reg    = i_cfg_data[0];
                    CFG_CONFIDENCE: conf_reg  = i_cfg_data[8:0];
                    CFG_LIMIT:      limit_reg = i_cfg_data[7:0];
                    CFG_BIRTH:      birth_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) apply_event(t_action'(i_action), i_now);
            if (i_valid) begin
                if (status_q.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    o_errors++;
                end else begin
                    want = status_q.pop_front();
                    o_results++;
                    if (i_estimate !== want.estimate) begin
                        $error("estimate: expected %0d, got %0d", want.estimate, i_estimate);
                        o_errors++;
                    end
                    if (i_avail_fraction !== want.fraction) begin
                        $error("avail_fraction: expected %0d, got %0d",
                               want.fraction, i_avail_fraction);
                        o_errors++;
                    end
                    if (i_last_interval !== want.last_len) begin
                        $error("last_interval: expected %0d, got %0d",
                               want.last_len, i_last_interval);
                        o_errors++;
                    end
                    if (i_available !== want.open) begin
                        $error("available: expected %0d, got %0d", want.open, i_available);
                        o_errors++;
                    end
                    if (i_open_since !== want.since) begin
                        $error("open_since: expected %0d, got %0d", want.since, i_open_since);
                        o_errors++;
                    end
                    if (i_history_count !== want.count) begin
                        $error("history_count: expected %0d, got %0d",
                               want.count, i_history_count);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ===== bench/availability_quantile_tracker_test.sv =====
`timescale 1ns / 1ps
// top of the availability quantile tracker bench: clock, reset, stimulus and verdict
// depends on aqt_pkg, availability_quantile_tracker and aqt_tb_checker
module availability_quantile_tracker_test;
    import aqt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [31:0] i_now;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [31:0] o_estimate;
    logic [15:0] o_avail_fraction;
    logic [31:0] o_last_interval;
    logic        o_available;
    logic [31:0] o_open_since;
    logic [7:0]  o_history_count;

    int errors;
    int pending;
    int results;
    int sent;
    int phases;
    int burst_left;
    bit gaps_on;
    int quiet_cycles;
    logic [31:0] clock_s;

    availability_quantile_tracker uut (.*);

    aqt_tb_checker u_tb_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_action, .i_now,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(o_valid), .i_estimate(o_estimate), .i_avail_fraction(o_avail_fraction),
        .i_last_interval(o_last_interval), .i_available(o_available),
        .i_open_since(o_open_since), .i_history_count(o_history_count),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog on cycles without any transaction or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // one event transaction, with bursts and gaps on the sender side
    task automatic send_event(input t_action act, input logic [31:0] t);
        if (gaps_on && burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        start    <= 1'b1;
        i_action <= act;
        i_now    <= t;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        burst_left--;
        sent++;
    endtask

    // drain outstanding transactions before touching registers
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed open/tick/close sessions, some raw noise
    task automatic run_sessions(input int count, input logic [31:0] max_len);
        int done;
        int ticks;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 99) < 85) begin
                clock_s += $urandom_range(0, 50);
                send_event(ACT_START, clock_s);
                ticks = $urandom_range(0, 3);
                repeat (ticks) begin
                    clock_s += $urandom_range(0, 2 * max_len);
                    send_event(ACT_TICK, clock_s);
                end
                clock_s += $urandom_range(0, max_len);
                send_event(ACT_END, clock_s);
                done += ticks + 2;
            end else begin
                send_event(t_action'($urandom_range(0, 3)), $urandom());
                done++;
            end
        end
    endtask

    initial begin
        logic [31:0] span;
        start      = 1'b0;
        i_action   = ACT_NONE;
        i_now      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ENABLE;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        sent       = 0;
        phases     = 0;
        burst_left = 0;
        gaps_on    = 1'b0;
        clock_s    = 32'd1000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle cases, reopen, backwards time, wrap, extremes
        send_event(ACT_END, 32'd100);
        send_event(ACT_TICK, 32'd0);
        send_event(ACT_START, 32'd10);
        send_event(ACT_START, 32'd20);
        send_event(ACT_TICK, 32'd15);
        send_event(ACT_TICK, 32'd5);
        send_event(ACT_END, 32'd50);
        send_event(ACT_NONE, 32'd60);
        send_event(ACT_TICK, 32'd70);
        send_event(ACT_START, 32'd80);
        send_event(ACT_TICK, 32'd200);
        send_event(ACT_END, 32'hFFFF_FFF0);
        send_event(ACT_START, 32'hFFFF_FFFF);
        send_event(ACT_TICK, 32'd3);
        send_event(ACT_END, 32'd0);
        settle();
        write_reg(CFG_CONFIDENCE, 32'd0);
        write_reg(CFG_BIRTH, 32'hFFFF_FFFF);
        send_event(ACT_START, 32'd100);
        send_event(ACT_TICK, 32'd101);
        send_event(ACT_END, 32'd102);
        settle();
        write_reg(CFG_CONFIDENCE, 32'd256);
        write_reg(CFG_LIMIT, 32'd0);
        send_event(ACT_START, 32'd110);
        send_event(ACT_TICK, 32'h8000_0000);
        send_event(ACT_END, 32'd120);
        settle();
        write_reg(CFG_CONFIDENCE, 32'h1FF);
        write_reg(CFG_ENABLE, 32'd0);
        send_event(ACT_START, 32'd130);
        send_event(ACT_TICK, 32'd140);
        settle();
        write_reg(CFG_ENABLE, 32'd1);
        phases = 1;

        // random phases over several register settings
        for (int p = 0; p < 9; p++) begin
            settle();
            gaps_on = (p % 3 != 2);
            case (p % 5)
                0: write_reg(CFG_CONFIDENCE, 32'd0);
                1: write_reg(CFG_CONFIDENCE, 32'd256);
                2: write_reg(CFG_CONFIDENCE, 32'd205);
                default: write_reg(CFG_CONFIDENCE, $urandom_range(0, 511));
            endcase
            case (p)
                0: write_reg(CFG_LIMIT, 32'd2);
                1: write_reg(CFG_LIMIT, 32'd128);
                2: write_reg(CFG_LIMIT, 32'd255);
                3: write_reg(CFG_LIMIT, 32'd1);
                default: write_reg(CFG_LIMIT, $urandom_range(2, 128));
            endcase
            case (p % 3)
                0: write_reg(CFG_BIRTH, 32'd0);
                1: write_reg(CFG_BIRTH, clock_s - $urandom_range(0, 5000));
                default: write_reg(CFG_BIRTH, $urandom());
            endcase
            write_reg(CFG_ENABLE, (p == 6) ? 32'd0 : 32'd1);
            case (p % 4)
                0: span = 32'd5;
                1: span = 32'd1000;
                2: span = 32'd40;
                default: span = 32'h7FFF_FFFF;
            endcase
            // the limit of 255 phase fills the history past its depth
            run_sessions((p == 2) ? 420 : 65, span);
            phases++;
        end

        settle();
        repeat (50) @(posedge i_clk);
        $display("sent %0d transactions over %0d register settings, %0d results checked",
                 sent, phases, results);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
